FILE: rtl/core/ppd_pkg.sv
// ----------------------------------------------------------------------------
// Pulse pile-up discriminator package
// Widths, the pulse-shape tap generator, saturation helpers and shared types.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int PULSE_TAPS = 301;
    localparam int AMP_W      = 24;

    localparam int HIT_W  = 4;
    localparam int TAP_W  = 18;
    localparam int TICK_W = 32;
    localparam int THR_W  = 24;
    localparam int PEAK_W = 24;
    localparam int PROD_W = TAP_W + HIT_W;
    localparam int SUM_W  = PROD_W + $clog2(PULSE_TAPS);
    localparam int CMP_W  = (AMP_W > THR_W) ? AMP_W : THR_W;
    localparam int SAT_W  = ((SUM_W > AMP_W) ? SUM_W : AMP_W) + 1;

    localparam logic signed [THR_W-1:0] THR_RESET = THR_W'(128);

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]        start_tick;
        logic signed [PEAK_W-1:0] peak_amplitude;
    } ppd_result_t;

    // Q4.28 arithmetic used to build the pulse-shape taps at elaboration.
    localparam longint QONE = 64'sd1 <<< 28;
    localparam longint LN2Q = (64'sd693147181 * QONE) / 64'sd1000000000;

    // Signed quotient truncated toward zero, by restoring long division on
    // the magnitudes. Used while building the tap table.
    function automatic longint qdiv(input longint n, input longint d);
        logic [63:0] mag_n;
        logic [63:0] mag_d;
        logic [63:0] quo;
        logic [64:0] rem;
        if (d == 0) begin
            return 0;
        end
        mag_n = (n < 0) ? -n : n;
        mag_d = (d < 0) ? -d : d;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], mag_n[i]};
            if (rem >= {1'b0, mag_d}) begin
                rem = rem - {1'b0, mag_d};
                quo[i] = 1'b1;
            end
        end
        return ((n < 0) != (d < 0)) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint qfrac(input longint n, input longint d);
        return qdiv(n * QONE, d);
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return qdiv(a * b, QONE);
    endfunction

    function automatic longint fdiv(input longint a, input longint b);
        if (b == 0) begin
            return 0;
        end
        return qdiv(a * QONE, b);
    endfunction

    // exp(y) for y <= 0 by ln2 range reduction and a 16-term series.
    function automatic longint fexp_neg(input longint y);
        longint u;
        longint k;
        longint r;
        longint acc;
        longint term;
        u = -y;
        k = qdiv(u, LN2Q);
        if (k >= 40) begin
            return 0;
        end
        r = u - k * LN2Q;
        acc = QONE;
        term = QONE;
        for (int n = 1; n <= 16; n++) begin
            term = -qdiv(qdiv(term * r, QONE), longint'(n));
            acc = acc + term;
        end
        return acc >> k;
    endfunction

    function automatic longint fexp(input longint y);
        longint yc;
        longint e;
        if (y > 0) begin
            yc = (y > 3 * QONE) ? 3 * QONE : y;
            e = fexp_neg(-yc);
            return (e > 0) ? qdiv(QONE * QONE, e) : 0;
        end
        return fexp_neg(y);
    endfunction

    // Rational part of erfc(z) * exp(z * z) for z >= 0.
    function automatic longint erfc_poly(input longint z);
        longint s;
        longint p;
        s = qdiv(QONE * QONE, QONE + fmul(qfrac(327591100, 1000000000), z));
        p = qfrac(1061405429, 1000000000);
        p = -qfrac(1453152027, 1000000000) + fmul(s, p);
        p = qfrac(1421413741, 1000000000) + fmul(s, p);
        p = -qfrac(284496736, 1000000000) + fmul(s, p);
        p = qfrac(254829592, 1000000000) + fmul(s, p);
        return fmul(s, p);
    endfunction

    function automatic longint emg(input longint t, input longint a, input longint b);
        longint sq2;
        longint pre;
        longint ex;
        longint z;
        longint tail;
        longint az;
        sq2 = qfrac(1414213562, 1000000000);
        pre = fmul(b, qfrac(1253314137, 1000000000));
        ex = fdiv(fmul(b, b), 2 * fmul(a, a)) - fdiv(t, a);
        z = fdiv(t, fmul(b, sq2)) - fdiv(b, fmul(a, sq2));
        if (z >= 0) begin
            if (z > 6 * QONE) begin
                tail = 2 * QONE;
            end else begin
                tail = 2 * QONE - fmul(erfc_poly(z), fexp(-fmul(z, z)));
            end
            return fmul(fmul(pre, fexp(ex)), tail);
        end
        az = -z;
        if (az > 6 * QONE) begin
            return 0;
        end
        return fmul(pre, fmul(erfc_poly(az), fexp(ex - fmul(az, az))));
    endfunction

    // Pulse-shape weight of one tap in units of 1/256, clamped to TAP_W bits.
    function automatic logic signed [TAP_W-1:0] shape_tap(input int k);
        longint a1;
        longint a2;
        longint b;
        longint gscale;
        longint den;
        longint t;
        longint d;
        longint v;
        longint vmax;
        a1 = qfrac(888913032, 1000000000);
        a2 = fmul(a1, QONE - qfrac(888913032, 64'sd65575636532));
        b = qfrac(416687779, 1000000000);
        gscale = 64'sd2124902715;
        den = 64'sd10000000 * 64'sd1048576;
        vmax = (64'sd1 <<< (TAP_W - 1)) - 1;
        t = qdiv(longint'(k) * QONE - 15 * QONE, 10);
        if (t > 60 * QONE) begin
            t = 60 * QONE;
        end
        d = emg(t, a1, b) - emg(t, a2, b);
        if (d > 4 * QONE) begin
            d = 4 * QONE;
        end
        if (d < -4 * QONE) begin
            d = -4 * QONE;
        end
        if (d >= 0) begin
            v = qdiv(d * gscale + qdiv(den, 2), den);
        end else begin
            v = -qdiv(-d * gscale + qdiv(den, 2), den);
        end
        if (v > vmax) begin
            v = vmax;
        end
        if (v < -vmax - 1) begin
            v = -vmax - 1;
        end
        return TAP_W'(v);
    endfunction

    // Clamp the full convolution sum to the signed amplitude range.
    function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [SUM_W-1:0] s);
        logic signed [SAT_W-1:0] w;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        w  = SAT_W'(s);
        hi = SAT_W'((64'sd1 <<< (AMP_W - 1)) - 1);
        lo = -hi - SAT_W'(1);
        if (w > hi) begin
            return AMP_W'(hi);
        end
        if (w < lo) begin
            return AMP_W'(lo);
        end
        return AMP_W'(w);
    endfunction

    // Clamp a peak to the reported PEAK_W-bit range.
    function automatic logic signed [PEAK_W-1:0] sat_peak(input logic signed [AMP_W-1:0] p);
        logic signed [CMP_W:0] w;
        logic signed [CMP_W:0] hi;
        logic signed [CMP_W:0] lo;
        w  = (CMP_W + 1)'(p);
        hi = (CMP_W + 1)'((64'sd1 <<< (PEAK_W - 1)) - 1);
        lo = -hi - (CMP_W + 1)'(1);
        if (w > hi) begin
            return PEAK_W'(hi);
        end
        if (w < lo) begin
            return PEAK_W'(lo);
        end
        return PEAK_W'(w);
    endfunction

endpackage

FILE: rtl/core/ppd_tap_cell.sv
// ----------------------------------------------------------------------------
// Pulse pile-up discriminator tap cell
// One tap of the transposed convolution: weight times hits plus the partial sum.
// ----------------------------------------------------------------------------
module ppd_tap_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              clear,
    input  logic [ppd_pkg::HIT_W-1:0]         hit,
    input  logic signed [ppd_pkg::TAP_W-1:0]  weight,
    input  logic signed [ppd_pkg::SUM_W-1:0]  p_in,
    output logic signed [ppd_pkg::SUM_W-1:0]  sum_out
);
    import ppd_pkg::*;

    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [PROD_W-1:0] prod;

    // The held value is the neighbor's sum from the previous tick, i.e. the
    // contribution of older hits that lands on this tap's position.
    always_comb
    begin
        acc_next = acc_reg;
        if (clear) begin
            acc_next = '0;
        end else if (advance) begin
            acc_next = p_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign prod    = $signed({1'b0, hit}) * weight;
    assign sum_out = SUM_W'(prod) + acc_reg;

endmodule

FILE: rtl/core/ppd_discriminator.sv
// ----------------------------------------------------------------------------
// Pulse pile-up discriminator threshold logic
// Tracks the armed state, start tick and peak, and flags finished pulses.
// ----------------------------------------------------------------------------
module ppd_discriminator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic signed [ppd_pkg::THR_W-1:0]  cfg_data,
    input  logic                              accept,
    input  logic                              kind,
    input  logic signed [ppd_pkg::AMP_W-1:0]  amp,
    output logic                              res_push,
    output ppd_pkg::ppd_result_t              res
);
    import ppd_pkg::*;

    logic signed [THR_W-1:0]  thr_reg;
    logic                     armed_reg;
    logic                     armed_next;
    logic signed [AMP_W-1:0]  peak_reg;
    logic signed [AMP_W-1:0]  peak_next;
    logic [TICK_W-1:0]        start_reg;
    logic [TICK_W-1:0]        start_next;
    logic [TICK_W-1:0]        tick_reg;
    logic [TICK_W-1:0]        tick_next;
    logic signed [CMP_W-1:0]  amp_x;
    logic signed [CMP_W-1:0]  thr_x;

    assign amp_x = CMP_W'(amp);
    assign thr_x = CMP_W'(thr_reg);

    always_comb
    begin
        armed_next = armed_reg;
        peak_next  = peak_reg;
        start_next = start_reg;
        tick_next  = tick_reg;
        res_push   = 1'b0;
        if (accept) begin
            if (kind == KIND_CLEAR) begin
                res_push   = armed_reg;
                armed_next = 1'b0;
                peak_next  = '0;
                start_next = '0;
                tick_next  = '0;
            end else begin
                tick_next = tick_reg + TICK_W'(1);
                priority if (!armed_reg) begin
                    if (amp_x > thr_x) begin
                        armed_next = 1'b1;
                        start_next = tick_reg;
                        peak_next  = amp;
                    end
                end else if (amp_x < thr_x) begin
                    res_push   = 1'b1;
                    armed_next = 1'b0;
                end else if (amp > peak_reg) begin
                    peak_next = amp;
                end
            end
        end
    end

    assign res.start_tick     = start_reg;
    assign res.peak_amplitude = sat_peak(peak_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg   <= THR_RESET;
            armed_reg <= 1'b0;
            peak_reg  <= '0;
            start_reg <= '0;
            tick_reg  <= '0;
        end else begin
            if (cfg_write) begin
                thr_reg <= cfg_data;
            end
            armed_reg <= armed_next;
            peak_reg  <= peak_next;
            start_reg <= start_next;
            tick_reg  <= tick_next;
        end
    end

endmodule

FILE: rtl/core/pulse_pileup_discriminator.sv
// ----------------------------------------------------------------------------
// Pulse pile-up discriminator
// Convolves hit counts with a fixed pulse shape and reports threshold pulses.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ---------------------------------------
//  input     in_valid / in_stall    kind, hit_count
//  output    out_valid / out_stall  start_tick, peak_amplitude
//  config    cfg_write              cfg_data (threshold, signed 1/256 units)
//
// One request is taken per clock cycle while in_stall is low. The output or
// skid register takes the report of a tick that ends a pulse (or the clear
// that closes an open pulse). The convolution lives in a row of tap cells,
// one multiply-add per cell, so the amplitude of a tick is ready in the
// same cycle it is accepted. Behind the output register sits one skid
// register; in_stall is raised only while that skid register is full.
// Reset sets the threshold to 128 (0.5) and clears all partial sums, the
// armed flag, the peak, the start tick and the tick counter.
//
module pulse_pileup_discriminator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic signed [ppd_pkg::THR_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [ppd_pkg::HIT_W-1:0]         hit_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ppd_pkg::TICK_W-1:0]        start_tick,
    output logic signed [ppd_pkg::PEAK_W-1:0] peak_amplitude
);
    import ppd_pkg::*;

    logic                    in_take;
    logic                    tick_adv;
    logic                    chan_clear;
    logic signed [SUM_W-1:0] tap_sum [PULSE_TAPS];
    logic signed [AMP_W-1:0] cur_amp;
    logic                    res_push;
    ppd_result_t             res;

    logic                    out_valid_reg;
    ppd_result_t             out_data_reg;
    logic                    skid_valid_reg;
    ppd_result_t             skid_data_reg;
    logic                    out_take;

    assign in_take    = in_valid && !in_stall;
    assign tick_adv   = in_take && (kind == KIND_TICK);
    assign chan_clear = in_take && (kind == KIND_CLEAR);

    // Transposed convolution. Cell k adds its weighted copy of the newest
    // hit count to what cell k+1 produced one tick earlier, so the output of
    // cell 0 is the full sum over the last PULSE_TAPS ticks. A clear empties
    // every cell, which drops all hits still pending in the pulse tails.
    for (genvar i = 0; i < PULSE_TAPS; i++) begin : g_tap
        localparam logic signed [TAP_W-1:0] TAP_WEIGHT = shape_tap(i);
        logic signed [SUM_W-1:0] p_in;

        if (i == PULSE_TAPS - 1) begin : g_last
            assign p_in = '0;
        end else begin : g_mid
            assign p_in = tap_sum[i + 1];
        end

        ppd_tap_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (tick_adv),
            .clear   (chan_clear),
            .hit     (hit_count),
            .weight  (TAP_WEIGHT),
            .p_in    (p_in),
            .sum_out (tap_sum[i])
        );
    end

    assign cur_amp = sat_amp(tap_sum[0]);

    ppd_discriminator u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (in_take),
        .kind      (kind),
        .amp       (cur_amp),
        .res_push  (res_push),
        .res       (res)
    );

    // Output register plus a skid register. A new result can only arrive
    // while the skid register is empty, so nothing is ever overwritten.
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || out_take) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= res_push;
                end
            end else if (res_push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (res_push) begin
                out_data_reg <= res;
            end
        end else if (res_push) begin
            skid_data_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign start_tick     = out_data_reg.start_tick;
    assign peak_amplitude = out_data_reg.peak_amplitude;

endmodule

FILE: tb/pulse_pileup_discriminator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pulse pile-up discriminator testbench
// Drives sample ticks and channel clears through the valid/stall handshake.
// Every pulse report is checked against an in-bench predictor. The predictor
// builds its own pulse-shape table and replays the convolution and the
// threshold discriminator for each accepted request.
// ----------------------------------------------------------------------------
module pulse_pileup_discriminator_test;

    import ppd_pkg::*;

    // Fixed-point scale of the pulse-shape construction (Q4.28).
    localparam longint Q_ONE = 64'sd1 <<< 28;
    localparam longint Q_LN2 = 64'sd693147181 * Q_ONE / 64'sd1000000000;

    localparam logic signed [THR_W-1:0] LEVEL_MIN = THR_W'(-(2 ** (THR_W - 1)));
    localparam logic signed [THR_W-1:0] LEVEL_MAX = THR_W'(2 ** (THR_W - 1) - 1);

    // A row of the directed script either moves the threshold or sends one
    // kind of request a number of times. Rows whose outcome is obvious carry
    // the expected report typed in; the others are left to the predictor.
    typedef enum logic [0:0] {ROW_LEVEL, ROW_ITEM} row_op_e;

    typedef struct packed {
        row_op_e                  op;
        logic                     kind;
        logic [HIT_W-1:0]         hits;
        logic [15:0]              reps;
        logic signed [THR_W-1:0]  level;
        logic                     typed;
        logic                     typed_has;
        logic [TICK_W-1:0]        typed_start;
        logic signed [PEAK_W-1:0] typed_peak;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic signed [THR_W-1:0]  cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     kind = KIND_TICK;
    logic [HIT_W-1:0]         hit_count = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [TICK_W-1:0]        start_tick;
    logic signed [PEAK_W-1:0] peak_amplitude;

    // Both sides stop idling while this is high; the receiver starts its
    // long hold-off once it sees hold_req.
    logic calm = 1'b0;
    logic hold_req = 1'b0;

    // Predictor state: one channel of the discriminator.
    int                      shape_w [PULSE_TAPS];
    logic [HIT_W-1:0]        hit_hist [PULSE_TAPS];
    logic signed [THR_W-1:0] level_now;
    bit                      pulse_open;
    longint                  peak_so_far;
    logic [TICK_W-1:0]       open_tick;
    logic [TICK_W-1:0]       tick_now;

    ppd_result_t pulses_due [$];
    int          mismatches = 0;

    script_row_t script_rows [0:27];

    pulse_pileup_discriminator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .hit_count      (hit_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .start_tick     (start_tick),
        .peak_amplitude (peak_amplitude)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Pulse-shape table. The weights are rebuilt here from the pulse formula
    // in the same signed Q4.28 integer arithmetic, with every product and
    // quotient truncated toward zero, so the table matches bit for bit.
    // ------------------------------------------------------------------------
    function automatic longint q_frac(input longint n, input longint d);
        return n * Q_ONE / d;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        return a * b / Q_ONE;
    endfunction

    function automatic longint q_div(input longint a, input longint b);
        if (b == 0)
        begin
            return 0;
        end
        return a * Q_ONE / b;
    endfunction

    // exp(y): positive arguments are capped at 3 and inverted; negative ones
    // are split into a multiple of ln2 (a shift) and a 16-term series.
    function automatic longint q_exp(input longint y);
        longint u;
        longint k;
        longint r;
        longint acc;
        longint term;
        longint inv;
        if (y > 0)
        begin
            inv = q_exp(-((y > 3 * Q_ONE) ? 3 * Q_ONE : y));
            return (inv > 0) ? Q_ONE * Q_ONE / inv : 0;
        end
        u = -y;
        k = u / Q_LN2;
        if (k >= 40)
        begin
            return 0;
        end
        r = u - k * Q_LN2;
        acc = Q_ONE;
        term = Q_ONE;
        for (int n = 1; n <= 16; n++)
        begin
            term = -(term * r / Q_ONE) / n;
            acc = acc + term;
        end
        return acc >> k;
    endfunction

    // Rational factor of erfc(z) * exp(z * z), z not negative.
    function automatic longint erfc_ratio(input longint z);
        longint s;
        longint p;
        s = Q_ONE * Q_ONE / (Q_ONE + q_mul(q_frac(327591100, 1000000000), z));
        p = q_frac(1061405429, 1000000000);
        p = q_mul(s, p) - q_frac(1453152027, 1000000000);
        p = q_mul(s, p) + q_frac(1421413741, 1000000000);
        p = q_mul(s, p) - q_frac(284496736, 1000000000);
        p = q_mul(s, p) + q_frac(254829592, 1000000000);
        return q_mul(s, p);
    endfunction

    // One exponentially modified Gaussian term of the pulse shape.
    function automatic longint emg_arm(input longint t, input longint a, input longint b);
        longint root2;
        longint pre;
        longint ex;
        longint z;
        longint tail;
        root2 = q_frac(1414213562, 1000000000);
        pre = q_mul(b, q_frac(1253314137, 1000000000));
        ex = q_div(q_mul(b, b), 2 * q_mul(a, a)) - q_div(t, a);
        z = q_div(t, q_mul(b, root2)) - q_div(b, q_mul(a, root2));
        if (z >= 0)
        begin
            if (z > 6 * Q_ONE)
            begin
                tail = 2 * Q_ONE;
            end
            else
            begin
                tail = 2 * Q_ONE - q_mul(erfc_ratio(z), q_exp(-q_mul(z, z)));
            end
            return q_mul(q_mul(pre, q_exp(ex)), tail);
        end
        if (-z > 6 * Q_ONE)
        begin
            return 0;
        end
        return q_mul(pre, q_mul(erfc_ratio(-z), q_exp(ex - q_mul(z, z))));
    endfunction

    // Weight of tap k in 1/256 units, rounded half away from zero and
    // clamped to the signed 18-bit tap range.
    function automatic int tap_weight(input int k);
        longint a1;
        longint a2;
        longint b;
        longint t;
        longint d;
        longint v;
        longint scale;
        longint den;
        a1 = q_frac(888913032, 1000000000);
        a2 = q_mul(a1, Q_ONE - q_frac(888913032, 64'sd65575636532));
        b = q_frac(416687779, 1000000000);
        scale = 64'sd2124902715;
        den = 64'sd10000000 * 64'sd1048576;
        t = (longint'(k) * Q_ONE - 15 * Q_ONE) / 10;
        if (t > 60 * Q_ONE)
        begin
            t = 60 * Q_ONE;
        end
        d = emg_arm(t, a1, b) - emg_arm(t, a2, b);
        if (d > 4 * Q_ONE)
        begin
            d = 4 * Q_ONE;
        end
        if (d < -4 * Q_ONE)
        begin
            d = -4 * Q_ONE;
        end
        if (d >= 0)
        begin
            v = (d * scale + den / 2) / den;
        end
        else
        begin
            v = -((-d * scale + den / 2) / den);
        end
        if (v > 131071)
        begin
            v = 131071;
        end
        if (v < -131072)
        begin
            v = -131072;
        end
        return int'(v);
    endfunction

    function automatic void drop_channel();
        for (int i = 0; i < PULSE_TAPS; i++)
        begin
            hit_hist[i] = '0;
        end
        pulse_open = 1'b0;
        peak_so_far = 0;
        open_tick = '0;
        tick_now = '0;
    endfunction

    // ------------------------------------------------------------------------
    // Predictor. Takes one accepted request, updates the channel and returns
    // 1 with the pulse report in rpt when the request closes a pulse. A clear
    // closes an open pulse with the peak seen so far. On a tick the newest
    // hit count enters tap 0, the convolution is saturated to the amplitude
    // range, and the discriminator compares it with the threshold: strictly
    // above opens, strictly below closes, equal does neither but still
    // counts toward the peak of an open pulse.
    // ------------------------------------------------------------------------
    function automatic bit shape_and_discriminate(input logic k, input logic [HIT_W-1:0] h,
                                                  output ppd_result_t rpt);
        longint amp;
        longint amp_hi;
        longint amp_lo;
        longint pk;
        longint pk_hi;
        bit     closed;
        amp_hi = (64'sd1 <<< (AMP_W - 1)) - 1;
        amp_lo = -amp_hi - 1;
        pk_hi = (64'sd1 <<< (PEAK_W - 1)) - 1;
        closed = 1'b0;
        pk = (peak_so_far > pk_hi) ? pk_hi : peak_so_far;
        pk = (pk < -pk_hi - 1) ? -pk_hi - 1 : pk;
        rpt.start_tick = open_tick;
        rpt.peak_amplitude = PEAK_W'(pk);
        if (k == KIND_CLEAR)
        begin
            closed = pulse_open;
            drop_channel();
            return closed;
        end
        for (int i = PULSE_TAPS - 1; i > 0; i--)
        begin
            hit_hist[i] = hit_hist[i - 1];
        end
        hit_hist[0] = h;
        amp = 0;
        for (int i = 0; i < PULSE_TAPS; i++)
        begin
            amp = amp + longint'(shape_w[i]) * longint'(hit_hist[i]);
        end
        amp = (amp > amp_hi) ? amp_hi : amp;
        amp = (amp < amp_lo) ? amp_lo : amp;
        if (!pulse_open)
        begin
            if (amp > longint'(level_now))
            begin
                pulse_open = 1'b1;
                open_tick = tick_now;
                peak_so_far = amp;
            end
        end
        else if (amp < longint'(level_now))
        begin
            closed = 1'b1;
            pulse_open = 1'b0;
        end
        else if (amp > peak_so_far)
        begin
            peak_so_far = amp;
        end
        tick_now = tick_now + 1'b1;
        return closed;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Idles at random outside the calm stretch, then holds the
    // request until an edge sees in_valid high with in_stall low. The
    // expected report, if any, is queued at that edge, before the block can
    // present it.
    // ------------------------------------------------------------------------
    task automatic offer_request(input logic k, input logic [HIT_W-1:0] h, input bit typed,
                                 input bit typed_has, input ppd_result_t typed_res);
        ppd_result_t predicted;
        bit          closes;
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        hit_count <= h;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        closes = shape_and_discriminate(k, h, predicted);
        if (typed)
        begin
            if (typed_has)
            begin
                pulses_due = {pulses_due, typed_res};
            end
        end
        else if (closes)
        begin
            pulses_due = {pulses_due, predicted};
        end
    endtask

    task automatic send_plain(input logic k, input logic [HIT_W-1:0] h);
        offer_request(k, h, 1'b0, 1'b0, '0);
    endtask

    // Threshold writes happen only with the block idle: the sender pauses,
    // every outstanding report is collected, and the bench waits longer since
    // a tick that closes nothing may still be in flight.
    task automatic set_level(input logic signed [THR_W-1:0] lvl);
        in_valid <= 1'b0;
        while (pulses_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= lvl;
        @(posedge clk);
        cfg_write <= 1'b0;
        level_now = lvl;
    endtask

    // ------------------------------------------------------------------------
    // Receiver. Checks every accepted report against the oldest expected one
    // and decides its stall for the next cycle: a single long hold-off on
    // request, otherwise random stalls outside the calm stretch.
    // ------------------------------------------------------------------------
    initial
    begin
        int          hold_left;
        bit          hold_taken;
        ppd_result_t want;
        hold_left = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pulses_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected report start %0d peak %0d",
                                              start_tick, peak_amplitude));
                end
                else
                begin
                    want = pulses_due.pop_front();
                    if (start_tick !== want.start_tick)
                    begin
                        report_mismatch($sformatf("start_tick %0d, predicted %0d",
                                                  start_tick, want.start_tick));
                    end
                    if (peak_amplitude !== want.peak_amplitude)
                    begin
                        report_mismatch($sformatf("peak_amplitude %0d, predicted %0d",
                                                  peak_amplitude, want.peak_amplitude));
                    end
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 18);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: reset, directed script, a back-pressure phase, then random
    // phases at a spread of thresholds, and the final drain.
    // ------------------------------------------------------------------------
    initial
    begin
        ppd_result_t             want;
        logic signed [THR_W-1:0] lvl;
        logic [HIT_W-1:0]        h;
        int                      rand_count;
        int                      phase;
        int                      phase_end;
        int                      pick;
        int                      burst;
        int                      gap;
        int                      spins;

        for (int i = 0; i < PULSE_TAPS; i++)
        begin
            shape_w[i] = tap_weight(i);
        end
        drop_channel();
        level_now = THR_RESET;

        // Directed script. After reset the threshold is 0.5, so an empty
        // history stays quiet and a clear with no open pulse says nothing.
        // At the lowest threshold an empty history already counts as a pulse
        // that never ends on its own, so the clear reports start 0, peak 0,
        // and a pulse carried far past the tap window is closed only by the
        // next clear. At the highest threshold the saturated sum can at most
        // equal it, and at zero an empty history equals it; neither opens a
        // pulse. The rest shows an ordinary pulse, a pile-up of two pulses,
        // and a slightly negative threshold.
        script_rows = '{
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd1,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd0,  16'd1,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_LEVEL, KIND_TICK,  4'd0,  16'd0,   LEVEL_MIN, 1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd1,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd3,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd15, 16'd1,   24'sd0,    1'b1, 1'b1, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd15, 16'd20,  24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd320, 24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd0,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_LEVEL, KIND_TICK,  4'd0,  16'd0,   LEVEL_MAX, 1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd15, 16'd30,  24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd0,  16'd1,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_LEVEL, KIND_TICK,  4'd0,  16'd0,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd2,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd1,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd300, 24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_LEVEL, KIND_TICK,  4'd0,  16'd0,   THR_RESET, 1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd8,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd300, 24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd15, 16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd7,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd40,  24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd15, 16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd300, 24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_LEVEL, KIND_TICK,  4'd0,  16'd0,   -24'sd1,   1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_TICK,  4'd0,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd0,  16'd1,   24'sd0,    1'b0, 1'b0, 32'd0, 24'sd0},
            '{ROW_ITEM,  KIND_CLEAR, 4'd9,  16'd1,   24'sd0,    1'b1, 1'b0, 32'd0, 24'sd0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[r])
        begin
            if (script_rows[r].op == ROW_LEVEL)
            begin
                set_level(script_rows[r].level);
            end
            else
            begin
                want.start_tick = script_rows[r].typed_start;
                want.peak_amplitude = script_rows[r].typed_peak;
                for (int n = 0; n < script_rows[r].reps; n++)
                begin
                    offer_request(script_rows[r].kind, script_rows[r].hits,
                                  script_rows[r].typed, script_rows[r].typed_has, want);
                end
            end
        end

        // Back-pressure: at the lowest threshold every tick opens a pulse and
        // every clear closes one, so reports come every other request. The
        // receiver holds off for a long stretch meanwhile, the output and
        // skid registers fill, and the block has to stall its input.
        set_level(LEVEL_MIN);
        hold_req <= 1'b1;
        for (int n = 0; n < 60; n++)
        begin
            send_plain(KIND_TICK, 4'($urandom_range(15)));
            send_plain(KIND_CLEAR, 4'($urandom_range(15)));
        end

        // Random phases. Each picks a threshold class and sends mostly bursts
        // of hits followed by quiet gaps, so pulses open, pile up and close;
        // short gaps give pile-up, long gaps let the history drain, some fully.
        // Clears and fully random requests are mixed in as noise.
        rand_count = 0;
        phase = 0;
        while (rand_count < 360)
        begin
            unique case (phase % 8)
                0: lvl = THR_RESET;
                1: lvl = THR_W'($urandom_range(1, 512));
                2: lvl = THR_W'($urandom_range(512, 8192));
                3: lvl = THR_W'($urandom_range(8192, 200000));
                4: lvl = THR_W'(0 - $urandom_range(1, 2000));
                5: lvl = LEVEL_MIN;
                6: lvl = LEVEL_MAX;
                default: lvl = THR_W'($urandom);
            endcase
            set_level(lvl);
            phase_end = rand_count + $urandom_range(40, 90);
            while (rand_count < phase_end)
            begin
                // A stretch in the middle of the random part runs with no idling.
                calm <= (rand_count >= 60 && rand_count < 260);
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    burst = $urandom_range(1, 8);
                    for (int n = 0; n < burst; n++)
                    begin
                        send_plain(($urandom_range(3) == 0) ? KIND_CLEAR : KIND_TICK,
                                   4'($urandom_range(15)));
                        rand_count++;
                    end
                end
                else if (pick < 18)
                begin
                    send_plain(KIND_CLEAR, 4'($urandom_range(15)));
                    rand_count++;
                end
                else
                begin
                    burst = $urandom_range(1, 6);
                    for (int n = 0; n < burst; n++)
                    begin
                        h = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                     : 4'($urandom_range(1, 3));
                        send_plain(KIND_TICK, h);
                        rand_count++;
                    end
                    gap = ($urandom_range(3) == 0) ? $urandom_range(150, 320)
                                                   : $urandom_range(0, 120);
                    for (int n = 0; n < gap; n++)
                    begin
                        send_plain(KIND_TICK, 4'd0);
                        rand_count++;
                    end
                end
            end
            phase++;
        end

        // Drain, allow the pipeline to settle, and give the verdict.
        in_valid <= 1'b0;
        spins = 0;
        while (pulses_due.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        if (pulses_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d pulse reports never arrived", pulses_due.size()));
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a block that hangs on its handshake.
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
